>>> sv/sha256md_pkg.sv
`default_nettype none
package sha256md_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic shift_msg;
    logic shift_pad;
    logic load;
    logic round;
    logic update;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic block_end;
    logic last_round;
    logic len_block;
    logic out_free;
  } status_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage
`default_nettype wire

>>> sv/sha256md_ctrl.sv
`default_nettype none
module sha256md_ctrl
  import sha256md_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     s_tvalid,
  input  wire     s_tuser,
  input  wire     s_tlast,
  input  status_t stat,
  output logic    s_tready,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   padding, padding_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      padding <= 1'b0;
    end else begin
      state   <= state_next;
      padding <= padding_next;
    end
  end

  always_comb begin
    state_next   = state;
    padding_next = padding;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser && stat.block_end) begin
            state_next   = ST_LOAD;
            padding_next = s_tlast;
          end else if (s_tlast) begin
            state_next   = ST_PAD;
            padding_next = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (stat.block_end) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: begin
        if (stat.last_round) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // the block holding the length closes the message
        if (!padding) state_next = ST_IDLE;
        else if (stat.len_block) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next   = ST_IDLE;
          padding_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_tready      = (state == ST_IDLE);
    cmd.shift_msg = (state == ST_IDLE) && s_tvalid && s_tuser;
    cmd.shift_pad = (state == ST_PAD);
    cmd.load      = (state == ST_LOAD);
    cmd.round     = (state == ST_ROUND);
    cmd.update    = (state == ST_UPDATE);
    cmd.emit      = (state == ST_EMIT) && stat.out_free;
  end

endmodule
`default_nettype wire

>>> sv/sha256md_dp.sv
`default_nettype none
module sha256md_dp
  import sha256md_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire  [7:0]   msg_byte,
  input  cmd_t         cmd,
  output status_t      stat,
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [255:0] m_tdata
);

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned amt);
    ror = (v >> amt) | (v << (32 - amt));
  endfunction

  // 64-byte window; oldest word at the top
  logic [511:0] win;
  logic [60:0]  byte_count;
  logic [5:0]   pos;
  logic [5:0]   rnd;
  logic         sent80;
  logic         len_block;
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [31:0]  hv [8];

  logic [63:0]  bit_len;
  logic [2:0]   len_idx;
  logic [7:0]   pad_byte;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  s0, s1, sig_a, sig_e, choose, major, t1, t2;

  assign bit_len = {byte_count, 3'b000};
  assign len_idx = 3'd7 - pos[2:0];

  always_comb begin
    if (!sent80) pad_byte = PAD_MARK;
    else if (len_block && pos >= LEN_POS) pad_byte = bit_len[{len_idx, 3'b000} +: 8];
    else pad_byte = 8'h00;
  end

  assign w0    = win[511:480];
  assign w1    = win[479:448];
  assign w9    = win[223:192];
  assign w14   = win[63:32];
  assign s0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  assign sig_e  = ror(ve, 6) ^ ror(ve, 11) ^ ror(ve, 25);
  assign choose = (ve & vf) ^ (~ve & vg);
  assign sig_a  = ror(va, 2) ^ ror(va, 13) ^ ror(va, 22);
  assign major  = (va & vb) ^ (va & vc) ^ (vb & vc);
  assign t1     = vh + sig_e + choose + K_TABLE[rnd] + w0;
  assign t2     = sig_a + major;

  always_ff @(posedge clk) begin
    if (cmd.shift_msg) win <= {win[503:0], msg_byte};
    else if (cmd.shift_pad) win <= {win[503:0], pad_byte};
    else if (cmd.round) win <= {win[479:0], w_new};

    if (cmd.load) begin
      va <= hv[0]; vb <= hv[1]; vc <= hv[2]; vd <= hv[3];
      ve <= hv[4]; vf <= hv[5]; vg <= hv[6]; vh <= hv[7];
    end else if (cmd.round) begin
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
    end

    if (cmd.emit) begin
      m_tdata <= {hv[6], hv[7], hv[4], hv[5], hv[2], hv[3], hv[0], hv[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      pos        <= '0;
      rnd        <= '0;
      sent80     <= 1'b0;
      len_block  <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= IV_TABLE[i];
    end else begin
      if (cmd.shift_msg) begin
        byte_count <= byte_count + 61'd1;
        pos        <= pos + 6'd1;
      end
      if (cmd.shift_pad) begin
        pos <= pos + 6'd1;
        if (!sent80) begin
          sent80    <= 1'b1;
          len_block <= (pos < LEN_POS);
        end
      end
      if (cmd.load) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.update) begin
        hv[0] <= hv[0] + va; hv[1] <= hv[1] + vb;
        hv[2] <= hv[2] + vc; hv[3] <= hv[3] + vd;
        hv[4] <= hv[4] + ve; hv[5] <= hv[5] + vf;
        hv[6] <= hv[6] + vg; hv[7] <= hv[7] + vh;
        // a marker block that overflowed leaves the length for the next one
        if (sent80) len_block <= 1'b1;
      end
      if (cmd.emit) begin
        byte_count <= '0;
        pos        <= '0;
        sent80     <= 1'b0;
        len_block  <= 1'b0;
        m_tvalid   <= 1'b1;
        for (int i = 0; i < 8; i++) hv[i] <= IV_TABLE[i];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.block_end  = (pos == 6'd63);
    stat.last_round = (rnd == 6'd63);
    stat.len_block  = len_block;
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire

>>> sv/sha256_message_digest_top.sv
// message bytes are taken one per cycle while idle; a full 64-byte block then holds input
// during compression (one load, 64 rounds of the single round unit, one chaining update)
// end of message: one pad byte per cycle (9 to 72) plus one or two compressions,
// then the EMIT state loads the output register once it is free
// the next message may start while the digest waits in the output register
// synchronous reset clears the byte count, loads the initial hash values and drops m_tvalid
`default_nettype none
module sha256_message_digest_top
  import sha256md_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,   // msg_byte
  input  wire          s_tuser,   // byte_present
  input  wire          s_tlast,   // end_of_message
  output logic         m_tvalid,
  input  wire          m_tready,
  // [63:0] digest_bits_255_192, [127:64] digest_bits_191_128,
  // [191:128] digest_bits_127_64, [255:192] digest_bits_63_0
  output logic [255:0] m_tdata
);

  cmd_t    cmd;
  status_t stat;

  sha256md_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  sha256md_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .msg_byte (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

>>> sv/sha256md_chk.sv
`default_nettype none
module sha256md_chk (
  input wire         clk,
  input wire         rst,
  input wire         s_tvalid,
  input wire         s_tready,
  input wire         s_tuser,
  input wire         s_tlast,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [255:0] m_tdata
);

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("digest changed while stalled");

  // padding and compression follow an end item, so no digest the next cycle
  a_end_no_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("digest appeared right after end item");

  // an end item always makes the block busy
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after end item");

  // an empty item without end changes nothing
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && !s_tlast |=> s_tready)
    else $error("empty item stalled input");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind sha256_message_digest_top sha256md_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [7:0] PAD_START = 8'h80;
  localparam int LEN_FIELD_POS = 56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;   // msg_byte
  logic         s_tuser = 1'b0;    // byte_present
  logic         s_tlast = 1'b0;    // end_of_message
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [63:0] digest_bits_255_192, [127:64] digest_bits_191_128,
  // [191:128] digest_bits_127_64, [255:192] digest_bits_63_0
  logic [255:0] m_tdata;

  sha256_message_digest_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // software copy of the hashing state
  logic [7:0]   msg_buf [64];
  logic [60:0]  msg_len;
  logic [31:0]  hash_state [8];
  logic [255:0] digest_queue [$];

  int src_idle_pct;
  int snk_idle_pct;
  int err_count;
  int quiet_cycles;
  logic [255:0] want_digest;

  string field_name [4] = '{"digest_bits_255_192", "digest_bits_191_128",
                            "digest_bits_127_64", "digest_bits_63_0"};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
    end
    for (t = 16; t < 64; t++) begin
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void digest_restart();
    msg_len = '0;
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
  endfunction

  // absorb one accepted item; on end of message pad, finish and queue the digest
  function automatic void digest_absorb(input logic [7:0] b, input logic present,
                                        input logic last);
    logic [63:0]  bit_len;
    logic [255:0] d;
    int pos;
    if (present) begin
      msg_buf[msg_len[5:0]] = b;
      msg_len = msg_len + 61'd1;
      if (msg_len[5:0] == 6'd0) sha_compress();
    end
    if (!last) return;
    bit_len = {msg_len, 3'b000};
    pos = int'(msg_len[5:0]);
    msg_buf[pos] = PAD_START;
    pos++;
    if (pos > LEN_FIELD_POS) begin
      while (pos < 64) begin
        msg_buf[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < LEN_FIELD_POS) begin
      msg_buf[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++) msg_buf[LEN_FIELD_POS + k] = bit_len[63 - 8*k -: 8];
    sha_compress();
    for (int k = 0; k < 4; k++) d[64*k +: 64] = {hash_state[2*k], hash_state[2*k+1]};
    digest_queue = {digest_queue, d};
    digest_restart();
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // digest checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest: expected none, got %h", m_tdata);
        err_count++;
      end else begin
        want_digest = digest_queue.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (m_tdata[64*k +: 64] !== want_digest[64*k +: 64]) begin
            $error("%s: expected %h, got %h", field_name[k], want_digest[64*k +: 64],
                   m_tdata[64*k +: 64]);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("** sha256_message_digest_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= present;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    digest_absorb(b, present, last);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);  // empty message
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);  // no byte, no end
    send_item(8'h63, 1'b1, 1'b1);                       // byte and end together
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);                       // end without a byte
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);                       // single byte message
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1);
  endtask

  // random messages, lengths biased toward the padding and block boundaries
  task automatic test_random_messages(input int n_items);
    int sent;
    int len;
    int pick;
    bit end_on_byte;
    int boundary_len [14] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) len = boundary_len[$urandom_range(0, 13)];
      else if (pick < 90) len = $urandom_range(1, 48);
      else len = $urandom_range(66, 200);
      end_on_byte = (len > 0) && $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          sent++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        sent++;
      end
      if (!end_on_byte) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    err_count = 0;
    src_idle_pct = 22;
    snk_idle_pct = 83;
    digest_restart();
    for (int i = 0; i < 64; i++) msg_buf[i] = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_messages(630);
    src_idle_pct = 83;
    snk_idle_pct = 22;
    test_random_messages(650);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_messages(650);
    s_tvalid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** sha256_message_digest_top: PASSED **");
    end else begin
      $display("** sha256_message_digest_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sha256_message_digest_top.f
sv/sha256md_pkg.sv
sv/sha256md_ctrl.sv
sv/sha256md_dp.sv
sv/sha256_message_digest_top.sv
sv/sha256md_chk.sv
tb/testbench.sv
